// ===== sv/ppt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg - shared types and constants of the pulse period tachometer
// Field widths, register reset values, event and register codes.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int CLK_W     = 28;   // timer_clock
    localparam int GAP_W     = 16;   // min_gap_us
    localparam int LIM_W     = 10;   // overflow_limit
    localparam int CFG_W     = 28;   // widest register
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int CAP_W     = 16;
    localparam int TS_W      = 32;
    localparam int IN_DATA_W = CAP_W + TS_W;
    localparam int RPM_W     = 32;
    localparam int SUM_W     = 48;
    localparam int PULSE_W   = 16;
    localparam int WRAP_W    = 10;
    localparam int CPW_W     = 16;
    localparam int ADD_W     = WRAP_W + CPW_W + 1;
    localparam int SCALE_W   = 16;
    localparam int NUM_W     = 60;   // 60000 * 200 MHz * 65535 < 2^60

    localparam logic [CPW_W-1:0]   COUNTS_PER_WRAP_DEF = 16'd65535;
    localparam logic [SCALE_W-1:0] RPM_SCALE           = 16'd60000;
    localparam logic [WRAP_W-1:0]  WRAP_MAX            = '1;

    localparam logic [CLK_W-1:0] TIMER_CLOCK_RST = 28'd16000000;
    localparam logic [GAP_W-1:0] MIN_GAP_RST     = 16'd3076;
    localparam logic [LIM_W-1:0] OVF_LIMIT_RST   = 10'd512;

    typedef enum logic [OP_W-1:0] {
        OP_EDGE  = 2'd0,
        OP_WRAP  = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CLOCK = 2'd0,
        CFG_MIN_GAP     = 2'd1,
        CFG_OVF_LIMIT   = 2'd2
    } cfg_idx_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse, result valid
    } unit_status_t;

endpackage
`default_nettype wire

// ===== sv/ppt_mult.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_mult - serial numerator multiplier
// Forms 60000 * timer_clock * pulses, one bit of the pulse count per cycle.
// ----------------------------------------------------------------------------
module ppt_mult (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire  [ppt_pkg::CLK_W-1:0]       timer_clock,
    input  wire  [ppt_pkg::PULSE_W-1:0]     pulses,
    output ppt_pkg::unit_status_t           status,
    output logic [ppt_pkg::NUM_W-1:0]       product
);

    localparam int CNT_W = $clog2(ppt_pkg::PULSE_W + 1);

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [ppt_pkg::NUM_W-1:0]     a_reg, a_next;
    logic [ppt_pkg::PULSE_W-1:0]   b_reg, b_next;
    logic [ppt_pkg::NUM_W-1:0]     acc_reg, acc_next;
    logic [ppt_pkg::NUM_W-1:0]     scaled_clock;

    assign scaled_clock = ppt_pkg::NUM_W'(ppt_pkg::RPM_SCALE)
                        * ppt_pkg::NUM_W'(timer_clock);

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            cnt_next = CNT_W'(ppt_pkg::PULSE_W);
            a_next   = scaled_clock;
            b_next   = pulses;
            acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next    = {a_reg[ppt_pkg::NUM_W-2:0], 1'b0};
            b_next    = {1'b0, b_reg[ppt_pkg::PULSE_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule
`default_nettype wire

// ===== sv/ppt_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_div - serial restoring divider
// One quotient bit per cycle; quotient saturates at the output width.
// ----------------------------------------------------------------------------
module ppt_div (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire  [ppt_pkg::NUM_W-1:0]       num,
    input  wire  [ppt_pkg::SUM_W-1:0]       den,
    output ppt_pkg::unit_status_t           status,
    output logic [ppt_pkg::RPM_W-1:0]       quot
);

    localparam int CNT_W = $clog2(ppt_pkg::NUM_W + 1);

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic                          ovf_reg, ovf_next;
    logic [ppt_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [ppt_pkg::SUM_W-1:0]     den_reg, den_next;
    logic [ppt_pkg::SUM_W-1:0]     rem_reg, rem_next;
    logic [ppt_pkg::RPM_W-1:0]     q_reg, q_next;
    logic [ppt_pkg::SUM_W:0]       trial;
    logic [ppt_pkg::SUM_W:0]       diff;
    logic                          fits;

    assign trial = {rem_reg, num_reg[ppt_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            cnt_next = CNT_W'(ppt_pkg::NUM_W);
            ovf_next = 1'b0;
            num_next = num;
            den_next = den;
            rem_next = '0;
            q_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below den, so the low bits are enough
            rem_next  = fits ? diff[ppt_pkg::SUM_W-1:0] : trial[ppt_pkg::SUM_W-1:0];
            num_next  = {num_reg[ppt_pkg::NUM_W-2:0], 1'b0};
            q_next    = {q_reg[ppt_pkg::RPM_W-2:0], fits};
            ovf_next  = ovf_reg | q_reg[ppt_pkg::RPM_W-1];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quot        = ovf_reg ? '1 : q_reg;

endmodule
`default_nettype wire

// ===== sv/pulse_period_tachometer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_period_tachometer_core - one-channel period-averaging speed meter
// Sums pulse periods between checks and reports mean speed in milli-rpm.
// ----------------------------------------------------------------------------
// Use:
//  - Input stream (s_*): one event per item. s_tuser selects the event kind
//    (pulse edge, timer wrap, periodic check); s_tdata carries the capture
//    count and the microsecond timestamp of the event.
//  - Output stream (m_*): one item per check that has something to report:
//    speed in thousandths of rpm on m_tdata, stall flag on m_tuser.
//  - Register port: cfg_we/cfg_index/cfg_wdata, write only, idle time only.
// Sequence:
//  - Wraps, quiet checks and edges that arm or bounce are handled in idle;
//    counted edges pass through an accumulate state that updates the period sum.
//  - A reporting check runs 16 steps of the bit-serial multiplier and 60 of
//    the restoring divider, then hands the result to the output register.
//    Stalled or empty sums skip the arithmetic and go straight to the output
//    state. A busy receiver holds the core in the output state.
//  - One event is in work at a time; s_tready is high whenever idle.
// Reset clears all meter state and loads the register defaults. A stalled
// receiver holds the result in the output register while events go on being
// taken; a second result waits in the core until the register frees.
// ----------------------------------------------------------------------------
module pulse_period_tachometer_core #(
    parameter logic [ppt_pkg::CPW_W-1:0] COUNTS_PER_WRAP = ppt_pkg::COUNTS_PER_WRAP_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // register write port
    input  wire                                cfg_we,
    input  wire  [ppt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [ppt_pkg::CFG_W-1:0]          cfg_wdata,
    // event stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [ppt_pkg::IN_DATA_W-1:0]      s_tdata,   // capture_count, now_us
    input  wire  [ppt_pkg::OP_W-1:0]           s_tuser,   // operation
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [ppt_pkg::RPM_W-1:0]          m_tdata,   // rpm_milli
    output logic [0:0]                         m_tuser    // stalled
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ACCUM = 5'b00010,
        ST_MULT  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // registers
    logic [ppt_pkg::CLK_W-1:0]   clock_reg, clock_next;
    logic [ppt_pkg::GAP_W-1:0]   gap_reg, gap_next;
    logic [ppt_pkg::LIM_W-1:0]   limit_reg, limit_next;

    // meter state
    logic                         fresh_reg, fresh_next;
    logic [ppt_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [ppt_pkg::PULSE_W-1:0]  pulse_reg, pulse_next;
    logic [ppt_pkg::WRAP_W-1:0]   wrap_reg, wrap_next;
    logic                         stall_reg, stall_next;
    logic [ppt_pkg::TS_W-1:0]     last_reg, last_next;

    // payload
    logic [ppt_pkg::ADD_W-1:0]    add_reg, add_next;
    logic [ppt_pkg::RPM_W-1:0]    res_rpm_reg, res_rpm_next;
    logic                         res_stall_reg, res_stall_next;
    logic                         m_valid_reg, m_valid_next;
    logic [ppt_pkg::RPM_W-1:0]    m_rpm_reg, m_rpm_next;
    logic                         m_stall_reg, m_stall_next;

    // event fields
    logic                         in_acc;
    logic [ppt_pkg::CAP_W-1:0]    cap;
    logic [ppt_pkg::TS_W-1:0]     now;
    logic [ppt_pkg::TS_W-1:0]     since_last;
    logic [ppt_pkg::SUM_W:0]      sum_wide;

    // serial arithmetic
    logic                         mult_start, div_start;
    ppt_pkg::unit_status_t        mult_st, div_st;
    logic [ppt_pkg::NUM_W-1:0]    product;
    logic [ppt_pkg::RPM_W-1:0]    quot;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign cap        = s_tdata[ppt_pkg::CAP_W-1:0];
    assign now        = s_tdata[ppt_pkg::IN_DATA_W-1:ppt_pkg::CAP_W];
    assign since_last = now - last_reg;   // modular, survives timestamp wrap
    assign sum_wide   = {1'b0, sum_reg} + (ppt_pkg::SUM_W+1)'(add_reg);
    assign div_start  = (state_reg == ST_MULT) && mult_st.done;

    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        gap_next       = gap_reg;
        limit_next     = limit_reg;
        fresh_next     = fresh_reg;
        sum_next       = sum_reg;
        pulse_next     = pulse_reg;
        wrap_next      = wrap_reg;
        stall_next     = stall_reg;
        last_next      = last_reg;
        add_next       = add_reg;
        res_rpm_next   = res_rpm_reg;
        res_stall_next = res_stall_reg;
        m_valid_next   = m_valid_reg;
        m_rpm_next     = m_rpm_reg;
        m_stall_next   = m_stall_reg;
        mult_start     = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                ppt_pkg::CFG_TIMER_CLOCK: clock_next = cfg_wdata[ppt_pkg::CLK_W-1:0];
                ppt_pkg::CFG_MIN_GAP:     gap_next   = cfg_wdata[ppt_pkg::GAP_W-1:0];
                ppt_pkg::CFG_OVF_LIMIT:   limit_next = cfg_wdata[ppt_pkg::LIM_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (s_tuser)
                        ppt_pkg::OP_EDGE:
                        begin
                            if (fresh_reg)
                            begin
                                // first edge arms the meter
                                sum_next   = '0;
                                pulse_next = '0;
                                wrap_next  = '0;
                                stall_next = 1'b0;
                                fresh_next = 1'b0;
                                last_next  = now;
                            end
                            else if (!stall_reg && since_last >= ppt_pkg::TS_W'(gap_reg))
                            begin
                                last_next  = now;
                                add_next   = ppt_pkg::ADD_W'(wrap_reg)
                                           * ppt_pkg::ADD_W'(COUNTS_PER_WRAP)
                                           + ppt_pkg::ADD_W'(cap);
                                if (pulse_reg != '1)
                                    pulse_next = pulse_reg + 1'b1;
                                wrap_next  = '0;
                                state_next = ST_ACCUM;
                            end
                        end
                        ppt_pkg::OP_WRAP:
                        begin
                            if (!stall_reg)
                            begin
                                if (ppt_pkg::LIM_W'(wrap_reg) > limit_reg
                                    || wrap_reg == ppt_pkg::WRAP_MAX)
                                begin
                                    wrap_next  = '0;
                                    stall_next = 1'b1;
                                end
                                else
                                    wrap_next = wrap_reg + 1'b1;
                            end
                        end
                        ppt_pkg::OP_CHECK:
                        begin
                            if (stall_reg || (!fresh_reg && pulse_reg != '0))
                            begin
                                fresh_next     = 1'b1;
                                res_stall_next = stall_reg;
                                if (stall_reg || sum_reg == '0)
                                begin
                                    res_rpm_next = '0;
                                    state_next   = ST_OUT;
                                end
                                else
                                begin
                                    mult_start = 1'b1;
                                    state_next = ST_MULT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ACCUM:
            begin
                sum_next   = sum_wide[ppt_pkg::SUM_W] ? '1 : sum_wide[ppt_pkg::SUM_W-1:0];
                state_next = ST_IDLE;
            end
            ST_MULT:
            begin
                if (mult_st.done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    res_rpm_next = quot;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_rpm_next   = res_rpm_reg;
                    m_stall_next = res_stall_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clock_reg   <= ppt_pkg::TIMER_CLOCK_RST;
            gap_reg     <= ppt_pkg::MIN_GAP_RST;
            limit_reg   <= ppt_pkg::OVF_LIMIT_RST;
            fresh_reg   <= 1'b1;
            sum_reg     <= '0;
            pulse_reg   <= '0;
            wrap_reg    <= '0;
            stall_reg   <= 1'b0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            gap_reg     <= gap_next;
            limit_reg   <= limit_next;
            fresh_reg   <= fresh_next;
            sum_reg     <= sum_next;
            pulse_reg   <= pulse_next;
            wrap_reg    <= wrap_next;
            stall_reg   <= stall_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_reg       <= add_next;
        res_rpm_reg   <= res_rpm_next;
        res_stall_reg <= res_stall_next;
        m_rpm_reg     <= m_rpm_next;
        m_stall_reg   <= m_stall_next;
    end

    ppt_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mult_start),
        .timer_clock (clock_reg),
        .pulses      (pulse_reg),
        .status      (mult_st),
        .product     (product)
    );

    ppt_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (product),
        .den    (sum_reg),
        .status (div_st),
        .quot   (quot)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_rpm_reg;
    assign m_tuser[0] = m_stall_reg;

endmodule
`default_nettype wire

// ===== tb/pulse_period_tachometer_core_tb.sv =====
// ----------------------------------------------------------------------------
// pulse_period_tachometer_core_tb - self-checking bench for the speed meter
// Drives pulse edge, timer wrap and check events with random gaps against a
// randomly stalling receiver. An in-bench copy of the meter predicts every
// speed reading, and each reading is checked field by field as it leaves.
// ----------------------------------------------------------------------------
module pulse_period_tachometer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // event code the block must ignore
    localparam logic [ppt_pkg::OP_W-1:0] OP_NONE = 2'd3;
    // worst-case cycles for a reporting check to leave the block, with margin
    localparam int SETTLE_CYCLES = 120;
    localparam int RUN_PHASES    = 8;
    localparam int PHASE_ITEMS   = 180;

    typedef struct packed {
        logic [ppt_pkg::RPM_W-1:0] rpm;
        logic                      stalled;
    } reading_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ppt_pkg::CFG_W-1:0]     cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ppt_pkg::IN_DATA_W-1:0] s_tdata;   // capture_count, now_us
    logic [ppt_pkg::OP_W-1:0]      s_tuser;   // operation
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ppt_pkg::RPM_W-1:0]     m_tdata;   // rpm_milli
    logic [0:0]                    m_tuser;   // stalled

    // register image
    logic [ppt_pkg::CLK_W-1:0] reg_clock;
    logic [ppt_pkg::GAP_W-1:0] reg_gap;
    logic [ppt_pkg::LIM_W-1:0] reg_limit;

    // meter image
    logic                        mtr_fresh;
    logic [ppt_pkg::SUM_W-1:0]   mtr_sum;
    logic [ppt_pkg::PULSE_W-1:0] mtr_pulses;
    logic [ppt_pkg::WRAP_W-1:0]  mtr_wraps;
    logic                        mtr_stall;
    logic [ppt_pkg::TS_W-1:0]    mtr_last_us;

    reading_t    readings_due[$];
    int          fail_count;
    int          items_sent;
    logic [ppt_pkg::TS_W-1:0] wall_us;     // stimulus timestamp, wraps freely
    int unsigned rdy_hold;
    int unsigned rdy_run;

    pulse_period_tachometer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // idle lengths: mostly none or short, now and then a long one
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // receiver: ready stretches broken by stalls of random length
    always @(posedge clk)
    begin
        if (rdy_hold != 0)
        begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end
        else if (rdy_run != 0)
        begin
            rdy_run  <= rdy_run - 1;
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= 1'b1;
            rdy_run  <= ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(0, 40);
            rdy_hold <= pick_gap();
        end
    end

    task automatic log_mismatch(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // meter prediction
    // ------------------------------------------------------------------------
    // mean speed in milli-rpm over the sums gathered since the cycle was armed
    function automatic logic [ppt_pkg::RPM_W-1:0] mean_speed();
        logic [63:0] num;
        logic [63:0] quo;
        if (mtr_stall || mtr_pulses == 0 || mtr_sum == 0)
            return '0;
        num = 64'd60000 * 64'(reg_clock) * 64'(mtr_pulses);
        quo = num / 64'(mtr_sum);
        return (quo > 64'hFFFF_FFFF) ? '1 : quo[ppt_pkg::RPM_W-1:0];
    endfunction

    task automatic meter_event(logic [ppt_pkg::OP_W-1:0] op,
                               logic [ppt_pkg::CAP_W-1:0] cap,
                               logic [ppt_pkg::TS_W-1:0] ts);
        logic [ppt_pkg::SUM_W-1:0] add;
        logic [ppt_pkg::TS_W-1:0]  since;
        since = ts - mtr_last_us;
        case (op)
            ppt_pkg::OP_EDGE:
            begin
                if (mtr_fresh)
                begin
                    // first edge arms the meter
                    mtr_sum     = '0;
                    mtr_pulses  = '0;
                    mtr_wraps   = '0;
                    mtr_stall   = 1'b0;
                    mtr_fresh   = 1'b0;
                    mtr_last_us = ts;
                end
                else if (!mtr_stall && since >= ppt_pkg::TS_W'(reg_gap))
                begin
                    mtr_last_us = ts;
                    add = ppt_pkg::SUM_W'(mtr_wraps)
                        * ppt_pkg::SUM_W'(ppt_pkg::COUNTS_PER_WRAP_DEF)
                        + ppt_pkg::SUM_W'(cap);
                    if (mtr_sum > {ppt_pkg::SUM_W{1'b1}} - add)
                        mtr_sum = '1;
                    else
                        mtr_sum = mtr_sum + add;
                    if (mtr_pulses != {ppt_pkg::PULSE_W{1'b1}})
                        mtr_pulses = mtr_pulses + 1'b1;
                    mtr_wraps = '0;
                end
            end
            ppt_pkg::OP_WRAP:
            begin
                if (!mtr_stall)
                begin
                    if (mtr_wraps > ppt_pkg::WRAP_W'(reg_limit)
                        || mtr_wraps >= ppt_pkg::WRAP_MAX)
                    begin
                        mtr_wraps = '0;
                        mtr_stall = 1'b1;
                    end
                    else
                        mtr_wraps = mtr_wraps + 1'b1;
                end
            end
            ppt_pkg::OP_CHECK:
            begin
                // nothing to report unless stalled or a pulse was counted
                if (mtr_stall || (!mtr_fresh && mtr_pulses != 0))
                begin
                    readings_due.push_back('{rpm: mean_speed(), stalled: mtr_stall});
                    mtr_fresh = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // reading checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_reading
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (readings_due.size() == 0)
                log_mismatch($sformatf("unexpected reading rpm_milli=%0d stalled=%0d",
                                       m_tdata, m_tuser));
            else
            begin
                want = readings_due.pop_front();
                if (m_tdata !== want.rpm)
                    log_mismatch($sformatf("rpm_milli expected %0d got %0d",
                                           want.rpm, m_tdata));
                if (m_tuser[0] !== want.stalled)
                    log_mismatch($sformatf("stalled expected %0d got %0d",
                                           want.stalled, m_tuser[0]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // one event; valid stays high into the next call when that has no gap
    task automatic send_item(logic [ppt_pkg::OP_W-1:0] op,
                             logic [ppt_pkg::CAP_W-1:0] cap,
                             logic [ppt_pkg::TS_W-1:0] ts);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ts, cap};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        meter_event(op, cap, ts);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // hold off until every reading is out and the core has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all three registers back to back; core must be idle
    task automatic load_regs(logic [ppt_pkg::CLK_W-1:0] tick_hz,
                             logic [ppt_pkg::GAP_W-1:0] gap_us,
                             logic [ppt_pkg::LIM_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= ppt_pkg::CFG_TIMER_CLOCK;
        cfg_wdata <= ppt_pkg::CFG_W'(tick_hz);
        @(posedge clk);
        cfg_index <= ppt_pkg::CFG_MIN_GAP;
        cfg_wdata <= ppt_pkg::CFG_W'(gap_us);
        @(posedge clk);
        cfg_index <= ppt_pkg::CFG_OVF_LIMIT;
        cfg_wdata <= ppt_pkg::CFG_W'(limit);
        @(posedge clk);
        cfg_we    <= 1'b0;
        reg_clock = tick_hz;
        reg_gap   = gap_us;
        reg_limit = limit;
    endtask

    function automatic logic [ppt_pkg::CAP_W-1:0] pick_capture();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return ppt_pkg::CAP_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // time to the next edge: mostly clear of the debounce gap, some bounces
    function automatic logic [ppt_pkg::TS_W-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12 && reg_gap != 0)
            return $urandom_range(0, reg_gap - 1);
        if (r < 15)
            return $urandom();
        return ppt_pkg::TS_W'(reg_gap) + $urandom_range(0, 20000);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset defaults: checks with nothing to report, wraps folded into the
    // period, debounce across the timestamp wrap, an unknown event code
    task automatic test_basic_cycle();
        logic [ppt_pkg::TS_W-1:0] t0;
        t0 = 32'hFFFF_F000;
        send_item(ppt_pkg::OP_CHECK, 16'h1234, 32'h0000_0100);  // fresh: no reading
        send_item(ppt_pkg::OP_EDGE,  16'hFFFF, t0);             // arm
        send_item(ppt_pkg::OP_CHECK, 16'h0000, t0 + 10);        // no pulses yet
        send_item(ppt_pkg::OP_WRAP,  16'h0000, t0 + 20);
        send_item(ppt_pkg::OP_WRAP,  16'hFFFF, t0 + 30);
        send_item(ppt_pkg::OP_EDGE,  16'hFFFF, t0 + 5000);      // crosses 2^32
        send_item(ppt_pkg::OP_EDGE,  16'h8000, t0 + 5100);      // bounce, ignored
        send_item(ppt_pkg::OP_EDGE,  16'h0000, t0 + 9000);
        send_item(OP_NONE,           16'hFFFF, 32'hFFFF_FFFF);
        send_item(ppt_pkg::OP_CHECK, 16'h0000, t0 + 9500);
        drain();
    endtask

    // speed saturation, empty period sum and zero timer clock
    task automatic test_special_speeds();
        load_regs(28'd200000000, 16'd0, 10'd1023);
        send_item(ppt_pkg::OP_EDGE,  16'h0000, 32'h0000_0000);
        send_item(ppt_pkg::OP_EDGE,  16'h0001, 32'h0000_0000);  // no gap needed
        send_item(ppt_pkg::OP_CHECK, 16'h0000, 32'h0000_0001);
        send_item(ppt_pkg::OP_EDGE,  16'hFFFF, 32'h8000_0000);
        send_item(ppt_pkg::OP_EDGE,  16'h0000, 32'h8000_0001);  // sum stays zero
        send_item(ppt_pkg::OP_CHECK, 16'h0000, 32'h8000_0002);
        drain();
        load_regs(28'd0, 16'd65535, 10'd1023);
        send_item(ppt_pkg::OP_EDGE,  16'h0000, 32'h1000_0000);
        send_item(ppt_pkg::OP_EDGE,  16'd500,  32'h1001_0000);
        send_item(ppt_pkg::OP_CHECK, 16'h0000, 32'h1001_0001);
        drain();
    endtask

    // wraps past the limit stall the meter until a fresh edge re-arms it
    task automatic test_stall();
        load_regs(28'd16000000, 16'd3076, 10'd1);
        send_item(ppt_pkg::OP_EDGE,  16'h0100, 32'h0000_4000);
        repeat (4) send_item(ppt_pkg::OP_WRAP, 16'h0000, 32'h0000_5000);
        send_item(ppt_pkg::OP_EDGE,  16'h0200, 32'h0010_0000);  // ignored while stalled
        send_item(ppt_pkg::OP_CHECK, 16'h0000, 32'h0010_0100);
        send_item(ppt_pkg::OP_CHECK, 16'h0000, 32'h0010_0200);  // still stalled
        send_item(ppt_pkg::OP_EDGE,  16'h0300, 32'h0020_0000);  // clears the stall
        drain();
    endtask

    // one measurement: arm, a few periods with wraps and bounces, then check
    task automatic run_measure_cycle();
        int unsigned n_edges;
        int unsigned n_wraps;
        n_edges = $urandom_range(1, 6);
        if ($urandom_range(0, 11) == 0)
            send_item(OP_NONE, pick_capture(), $urandom());
        if ($urandom_range(0, 11) == 0)
            send_item(ppt_pkg::OP_CHECK, pick_capture(), wall_us);
        wall_us = wall_us + $urandom_range(0, 3000);
        send_item(ppt_pkg::OP_EDGE, pick_capture(), wall_us);
        repeat (n_edges)
        begin
            n_wraps = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 60)
                                                   : $urandom_range(0, 3);
            repeat (n_wraps) send_item(ppt_pkg::OP_WRAP, pick_capture(), wall_us);
            wall_us = wall_us + pick_step();
            send_item(ppt_pkg::OP_EDGE, pick_capture(), wall_us);
        end
        // drive into a stall now and then when the limit is cheap to reach
        if (reg_limit <= 60 && $urandom_range(0, 7) == 0)
            repeat (int'(reg_limit) + 2)
                send_item(ppt_pkg::OP_WRAP, pick_capture(), wall_us);
        wall_us = wall_us + $urandom_range(0, 500);
        send_item(ppt_pkg::OP_CHECK, pick_capture(), wall_us);
        if ($urandom_range(0, 29) == 0)
            drain();
    endtask

    // phases under varied registers, extremes included
    task automatic test_random_runs();
        int unsigned phase;
        int          stop_at;
        logic [ppt_pkg::CLK_W-1:0] tick_hz;
        logic [ppt_pkg::GAP_W-1:0] gap_us;
        logic [ppt_pkg::LIM_W-1:0] limit;
        for (phase = 0; phase < RUN_PHASES; phase++)
        begin
            tick_hz = (phase == 0) ? 28'd1 :
                      (phase == 1) ? 28'd200000000 :
                      ppt_pkg::CLK_W'($urandom_range(1, 200000000));
            gap_us  = (phase == 2) ? 16'd0 :
                      (phase == 3) ? 16'd65535 :
                      ppt_pkg::GAP_W'($urandom_range(0, 8000));
            limit   = (phase == 4) ? 10'd1023 :
                      (phase == 5) ? 10'd1 :
                      ppt_pkg::LIM_W'($urandom_range(1, 24));
            load_regs(tick_hz, gap_us, limit);
            wall_us = $urandom();
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
                run_measure_cycle();
            drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= ppt_pkg::CFG_TIMER_CLOCK;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ppt_pkg::OP_EDGE;
        m_tready  <= 1'b0;
        rdy_hold   = 0;
        rdy_run    = 0;
        fail_count = 0;
        items_sent = 0;
        wall_us    = '0;
        reg_clock   = ppt_pkg::TIMER_CLOCK_RST;
        reg_gap     = ppt_pkg::MIN_GAP_RST;
        reg_limit   = ppt_pkg::OVF_LIMIT_RST;
        mtr_fresh   = 1'b1;
        mtr_sum     = '0;
        mtr_pulses  = '0;
        mtr_wraps   = '0;
        mtr_stall   = 1'b0;
        mtr_last_us = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_cycle();
        test_special_speeds();
        test_stall();
        test_random_runs();

        drain();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
